/* sv/apc_matrix_correction_assert.svh */
// Assertion macros for the APC block, clocked on i_clk, off while i_rst_n is low.
`ifndef APC_MATRIX_CORRECTION_ASSERT_SVH
`define APC_MATRIX_CORRECTION_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define APC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define APC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/apc_pkg.sv */
`timescale 1ns / 1ps

package apc_pkg;

    localparam int MAX_DIM_DEF = 128;

    localparam int IDX_W  = 7;
    localparam int SIZE_W = 8;
    localparam logic [SIZE_W-1:0] SIZE_RST = 8'd128;
    localparam int VAL_W  = 32;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    // stream payload: row, col, value, padded to whole bytes
    localparam int IN_DATA_W  = ((2 * IDX_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = VAL_W;

    localparam int SUM_W     = 40;  // column sum
    localparam int TOT_W     = 46;  // total sum
    localparam int Q_W       = 35;  // quotient bits resolved by the divider
    localparam int MUL_SPLIT = 20;  // low slice of the first multiplier operand

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_TOTAL_ZERO = 2'd1,
        ST_RANGE      = 2'd2
    } t_stat;

    typedef struct packed {
        logic entry_we;
        logic col_we;
    } t_mem_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_quot_stat;

endpackage

/* sv/apc_mem.sv */
`timescale 1ns / 1ps

module apc_mem #(
    parameter int MAX_DIM = apc_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  apc_pkg::t_mem_ctl               i_ctl,
    input  logic [2*$clog2(MAX_DIM)-1:0]    i_entry_addr,
    input  logic [apc_pkg::VAL_W-1:0]       i_entry_wdata,
    output logic [apc_pkg::VAL_W-1:0]       o_entry_rdata,
    input  logic [$clog2(MAX_DIM)-1:0]      i_col_addr,
    input  logic [apc_pkg::SUM_W-1:0]       i_col_wdata,
    output logic [apc_pkg::SUM_W-1:0]       o_col_rdata
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int ENTRY_DEPTH = 1 << (2 * IW);

    logic [apc_pkg::VAL_W-1:0] r_entry_mem [0:ENTRY_DEPTH-1];
    logic [apc_pkg::SUM_W-1:0] r_col_mem   [0:MAX_DIM-1];

    logic [apc_pkg::VAL_W-1:0] r_entry_rd;
    logic [apc_pkg::SUM_W-1:0] r_col_rd;

    // read-first, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.entry_we) begin
            r_entry_mem[i_entry_addr] <= i_entry_wdata;
        end
        r_entry_rd <= r_entry_mem[i_entry_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.col_we) begin
            r_col_mem[i_col_addr] <= i_col_wdata;
        end
        r_col_rd <= r_col_mem[i_col_addr];
    end

    assign o_entry_rdata = r_entry_rd;
    assign o_col_rdata   = r_col_rd;

endmodule

/* sv/apc_quot.sv */
`timescale 1ns / 1ps

// |a*b| / |t|, truncated, clamped to 2^(Q_W-1).
module apc_quot (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [apc_pkg::SUM_W-1:0]     i_ma,
    input  logic [apc_pkg::SUM_W-1:0]     i_mb,
    input  logic [apc_pkg::TOT_W-1:0]     i_mt,
    output logic [apc_pkg::Q_W-1:0]       o_q,
    output apc_pkg::t_quot_stat           o_stat
);

    localparam int SW     = apc_pkg::SUM_W;
    localparam int TW     = apc_pkg::TOT_W;
    localparam int QW     = apc_pkg::Q_W;
    localparam int LO_W   = apc_pkg::MUL_SPLIT;
    localparam int HI_W   = SW - LO_W;
    localparam int PP_W   = LO_W + SW;
    localparam int PROD_W = 2 * SW;
    localparam int CNT_W  = $clog2(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);
    localparam logic [QW-1:0] Q_MAX = {1'b1, {(QW-1){1'b0}}};

    typedef enum logic [6:0] {
        Q_IDLE = 7'b0000001,
        Q_MUL0 = 7'b0000010,
        Q_MUL1 = 7'b0000100,
        Q_SUM  = 7'b0001000,
        Q_CHK  = 7'b0010000,
        Q_DIV  = 7'b0100000,
        Q_DONE = 7'b1000000
    } t_qstate;

    t_qstate           r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic [SW-1:0]     r_a, r_b;
    logic [TW-1:0]     r_t;
    logic [PP_W-1:0]   r_pp0, r_pp1;
    logic [PROD_W-1:0] r_prod;
    logic [TW-1:0]     r_rem;
    logic [QW-1:0]     r_low;
    logic [QW-1:0]     r_q;

    logic [TW:0]       trial;
    logic [TW:0]       diff;
    logic              fits;
    logic              big;

    assign trial = {r_rem, r_low[QW-1]};
    assign diff  = trial - {1'b0, r_t};
    assign fits  = trial >= {1'b0, r_t};
    // quotient of 2^QW or more: top bits of the product already reach the divisor
    assign big   = TW'(r_prod[PROD_W-1:QW]) >= r_t;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            Q_IDLE: begin
                if (i_start) begin
                    n_state = Q_MUL0;
                end
            end
            Q_MUL0: n_state = Q_MUL1;
            Q_MUL1: n_state = Q_SUM;
            Q_SUM:  n_state = Q_CHK;
            Q_CHK: begin
                n_cnt   = '0;
                n_state = big ? Q_DONE : Q_DIV;
            end
            Q_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = Q_DONE;
                end
            end
            Q_DONE: n_state = Q_IDLE;
            default: n_state = Q_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            Q_IDLE: begin
                r_a <= i_ma;
                r_b <= i_mb;
                r_t <= i_mt;
            end
            Q_MUL0: r_pp0 <= {{(PP_W-LO_W){1'b0}}, r_a[LO_W-1:0]} * {{(PP_W-SW){1'b0}}, r_b};
            Q_MUL1: r_pp1 <= {{(PP_W-HI_W){1'b0}}, r_a[SW-1:LO_W]} * {{(PP_W-SW){1'b0}}, r_b};
            Q_SUM:  r_prod <= {{(PROD_W-PP_W){1'b0}}, r_pp0} + {r_pp1, {LO_W{1'b0}}};
            Q_CHK: begin
                r_rem <= TW'(r_prod[PROD_W-1:QW]);
                r_low <= r_prod[QW-1:0];
                r_q   <= big ? Q_MAX : '0;
            end
            Q_DIV: begin
                r_rem <= fits ? diff[TW-1:0] : trial[TW-1:0];
                r_low <= {r_low[QW-2:0], 1'b0};
                r_q   <= {r_q[QW-2:0], fits};
            end
            default: begin
            end
        endcase
    end

    assign o_q         = (r_q > Q_MAX) ? Q_MAX : r_q;
    assign o_stat.busy = (r_state != Q_IDLE);
    assign o_stat.done = (r_state == Q_DONE);

endmodule

/* sv/apc_matrix_correction.sv */
`timescale 1ns / 1ps
//  channel      dir   handshake                          payload
//  s_axis       in    i_s_axis_tvalid / o_s_axis_tready  tuser: req_type
//                                                        tdata: row, col, entry_value
//  m_axis       out   o_m_axis_tvalid / i_m_axis_tready  tdata: corrected_value
//                                                        tuser: status
//  cfg          in    i_cfg_valid / o_cfg_ready          matrix_size
//
//  Load: column sum read, then read-modify-write of the sum and the entry.
//  Read: row sum and entry read, column sum read, 20x40 multiply in two halves, add, clamp check,
//  35 divider steps, done, result, idle; the divider steps are skipped past the clamp.
//  Errors and diagonal go straight to the result. Clear and reset: a sweep zeroes the column sums, no beat taken.
//  A result beat waits in the output register while the next item is taken; a later
//  result holds in its last step until the register is free.
`include "apc_matrix_correction_assert.svh"

module apc_matrix_correction #(
    parameter int MAX_DIM = apc_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [6:0] row_index, [13:7] col_index, [45:14] entry_value, [47:46] zero
    input  logic [apc_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [1:0] req_type
    input  logic [apc_pkg::REQ_W-1:0]         i_s_axis_tuser,

    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [31:0] corrected_value
    output logic [apc_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // [1:0] status
    output logic [apc_pkg::STAT_W-1:0]        o_m_axis_tuser,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [apc_pkg::SIZE_W-1:0]        i_cfg_data
);

    localparam int IW  = $clog2(MAX_DIM);
    localparam int XW  = (IW > apc_pkg::IDX_W) ? IW : apc_pkg::IDX_W;
    localparam int DW  = apc_pkg::IDX_W;
    localparam int VW  = apc_pkg::VAL_W;
    localparam int SW  = apc_pkg::SUM_W;
    localparam int TW  = apc_pkg::TOT_W;
    localparam int QW  = apc_pkg::Q_W;
    localparam int RW  = VW + (QW - VW) + 2;   // entry minus signed quotient
    localparam logic [IW-1:0] SWEEP_LAST = IW'(MAX_DIM - 1);

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,  // zero sweep of the column sums
        S_IDLE  = 9'b000000010,
        S_LD_RD = 9'b000000100,  // column sum read in flight
        S_LD_WR = 9'b000001000,  // sum add and write-back, entry write
        S_RD_A  = 9'b000010000,  // read row's sum and entry
        S_RD_B  = 9'b000100000,  // read col's sum
        S_RD_C  = 9'b001000000,  // start divider
        S_DIV   = 9'b010000000,
        S_RES   = 9'b100000000   // hand result to the output register
    } t_state;

    function automatic logic [SW-1:0] f_mag_sum(input logic [SW-1:0] v);
        f_mag_sum = v[SW-1] ? (~v + SW'(1)) : v;
    endfunction

    function automatic logic [TW-1:0] f_mag_tot(input logic [TW-1:0] v);
        f_mag_tot = v[TW-1] ? (~v + TW'(1)) : v;
    endfunction

    // ---------------------------------------------------------------- state
    t_state                       r_state, n_state;
    logic [IW-1:0]                r_sweep, n_sweep;
    logic [TW-1:0]                r_total, n_total;
    logic [apc_pkg::SIZE_W-1:0]   r_size;
    logic                         r_out_valid, n_out_valid;

    // item and working registers
    logic [DW-1:0]                r_row, r_col;
    logic [VW-1:0]                r_val;
    logic [VW-1:0]                r_ent;
    logic [SW-1:0]                r_ma;
    logic                         r_na;
    logic [TW-1:0]                r_mt;
    logic                         r_nt;
    logic                         r_neg;
    logic [VW-1:0]                r_res;
    apc_pkg::t_stat               r_stat;
    logic [VW-1:0]                r_out_data;
    apc_pkg::t_stat               r_out_stat;

    // ---------------------------------------------------------------- input decode
    apc_pkg::t_req                in_req;
    logic [DW-1:0]                in_row, in_col;
    logic [VW-1:0]                in_val;
    logic                         in_ok;
    logic                         in_accept;

    assign in_req = apc_pkg::t_req'(i_s_axis_tuser);
    assign in_row = i_s_axis_tdata[DW-1:0];
    assign in_col = i_s_axis_tdata[2*DW-1:DW];
    assign in_val = i_s_axis_tdata[2*DW+VW-1:2*DW];

    // index must be below both the configured size and the built depth
    assign in_ok = (apc_pkg::SIZE_W'(in_row) < r_size) &&
                   (apc_pkg::SIZE_W'(in_col) < r_size) &&
                   (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // ---------------------------------------------------------------- memories
    apc_pkg::t_mem_ctl            mem_ctl;
    logic [XW-1:0]                row_x, col_x;
    logic [IW-1:0]                col_addr;
    logic [SW-1:0]                col_wdata;
    logic [SW-1:0]                col_rdata;
    logic [VW-1:0]                entry_rdata;
    logic [SW-1:0]                col_sum_new;

    assign row_x = XW'(r_row);
    assign col_x = XW'(r_col);

    assign col_sum_new = col_rdata + {{(SW-VW){r_val[VW-1]}}, r_val};

    // Sequencing is the interlock: a sum written in S_LD_WR is read back
    // only after a pass through S_IDLE, so no forwarding path is needed.
    always_comb begin
        mem_ctl.col_we   = (r_state == S_CLR) || (r_state == S_LD_WR);
        mem_ctl.entry_we = (r_state == S_LD_WR);
        if (r_state == S_CLR) begin
            col_addr  = r_sweep;
            col_wdata = '0;
        end else begin
            col_addr  = (r_state == S_RD_A) ? row_x[IW-1:0] : col_x[IW-1:0];
            col_wdata = col_sum_new;
        end
    end

    apc_mem #(
        .MAX_DIM (MAX_DIM)
    ) u_mem (
        .i_clk         (i_clk),
        .i_ctl         (mem_ctl),
        .i_entry_addr  ({row_x[IW-1:0], col_x[IW-1:0]}),
        .i_entry_wdata (r_val),
        .o_entry_rdata (entry_rdata),
        .i_col_addr    (col_addr),
        .i_col_wdata   (col_wdata),
        .o_col_rdata   (col_rdata)
    );

    // ---------------------------------------------------------------- divider
    logic                         quot_start;
    logic [QW-1:0]                quot_q;
    apc_pkg::t_quot_stat          quot_stat;

    assign quot_start = (r_state == S_RD_C);

    apc_quot u_quot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (quot_start),
        .i_ma    (r_ma),
        .i_mb    (f_mag_sum(col_rdata)),
        .i_mt    (r_mt),
        .o_q     (quot_q),
        .o_stat  (quot_stat)
    );

    // entry minus signed quotient, saturated to 32 bits
    logic [RW-1:0]                sq;
    logic [RW-1:0]                diff;
    logic [VW-1:0]                sat;

    assign sq   = r_neg ? (~RW'(quot_q) + RW'(1)) : RW'(quot_q);
    assign diff = {{(RW-VW){r_ent[VW-1]}}, r_ent} - sq;

    always_comb begin
        if (!diff[RW-1] && (|diff[RW-2:VW-1])) begin
            sat = {1'b0, {(VW-1){1'b1}}};
        end else if (diff[RW-1] && !(&diff[RW-2:VW-1])) begin
            sat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            sat = diff[VW-1:0];
        end
    end

    // ---------------------------------------------------------------- control
    logic                         out_load;

    assign out_load = (r_state == S_RES) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
        unique case (r_state)
            S_CLR: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == SWEEP_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    unique case (in_req)
                        apc_pkg::REQ_LOAD: begin
                            if (in_ok) begin
                                n_state = S_LD_RD;
                            end
                        end
                        apc_pkg::REQ_READ: begin
                            if (in_ok && (r_total != '0) && (in_row != in_col)) begin
                                n_state = S_RD_A;
                            end else begin
                                n_state = S_RES;
                            end
                        end
                        apc_pkg::REQ_CLEAR: begin
                            n_total = '0;
                            n_sweep = '0;
                            n_state = S_CLR;
                        end
                        apc_pkg::REQ_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LD_RD: n_state = S_LD_WR;
            S_LD_WR: begin
                n_total = r_total + {{(TW-VW){r_val[VW-1]}}, r_val};
                n_state = S_IDLE;
            end
            S_RD_A: n_state = S_RD_B;
            S_RD_B: n_state = S_RD_C;
            S_RD_C: n_state = S_DIV;
            S_DIV: begin
                if (quot_stat.done) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_sweep     <= '0;
            r_total     <= '0;
            r_size      <= apc_pkg::SIZE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_row <= in_row;
            r_col <= in_col;
            r_val <= in_val;
            // early answers: range, then zero total, then diagonal
            r_res <= '0;
            if (!in_ok) begin
                r_stat <= apc_pkg::ST_RANGE;
            end else if (r_total == '0) begin
                r_stat <= apc_pkg::ST_TOTAL_ZERO;
            end else begin
                r_stat <= apc_pkg::ST_OK;
            end
        end
        if (r_state == S_RD_A) begin
            r_mt <= f_mag_tot(r_total);
            r_nt <= r_total[TW-1];
        end
        if (r_state == S_RD_B) begin
            r_ma  <= f_mag_sum(col_rdata);
            r_na  <= col_rdata[SW-1];
            r_ent <= entry_rdata;
        end
        if (r_state == S_RD_C) begin
            r_neg <= r_na ^ col_rdata[SW-1] ^ r_nt;
        end
        if ((r_state == S_DIV) && quot_stat.done) begin
            r_res  <= sat;
            r_stat <= apc_pkg::ST_OK;
        end
        if (out_load) begin
            r_out_data <= r_res;
            r_out_stat <= r_stat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_stat;

    // ---------------------------------------------------------------- checks
    `APC_ASSERT_NOW(a_quot_done_waited, quot_stat.done, r_state == S_DIV, "divider done outside wait")
    `APC_ASSERT_NOW(a_quot_start_free, quot_start, !quot_stat.busy, "divider started while busy")
    `APC_ASSERT_NOW(a_err_value_zero, o_m_axis_tvalid && (o_m_axis_tuser != apc_pkg::ST_OK), o_m_axis_tdata == '0, "error beat with nonzero value")
    `APC_ASSERT_NEXT(a_result_held, (r_state == S_RES) && r_out_valid && !i_m_axis_tready, r_state == S_RES, "result dropped while output stalled")

endmodule
